>>> sv/tghc_pkg.sv
// ----------------------------------------------------------------------------
// tghc_pkg
// Shared types and constants for the time-gap hit clusterer.
// ----------------------------------------------------------------------------
package tghc_pkg;

   // defaults of the top-level parameters
   localparam int MAX_HITS_DEF  = 64;
   localparam int TIME_BITS_DEF = 20;

   // fixed field widths
   localparam int HIT_TIME_W = 20;
   localparam int GAP_W      = 20;
   localparam int MINH_W     = 7;
   localparam int IDX_OUT_W  = 6;
   localparam int TOT_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [GAP_W-1:0]  MAX_GAP_RST  = 20'd120;
   localparam logic [MINH_W-1:0] MIN_HITS_RST = 7'd4;

   // register index codes (paddr bit 2)
   localparam logic REG_MAX_GAP  = 1'b0;
   localparam logic REG_MIN_HITS = 1'b1;

   typedef struct packed {
      logic [HIT_TIME_W-1:0] hit_time;
      logic                  last_hit;
   } req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] hit_index;
      logic [IDX_OUT_W-1:0] group_number;
      logic                 kept;
      logic [IDX_OUT_W-1:0] subevent_number;
      logic [TOT_W-1:0]     subevent_total;
      logic                 overflowed;
      logic                 last_result;
   } rsp_type;

   // control handed to every sort cell
   typedef struct packed {
      logic ins;
      logic shl;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_FLUSH,
      ST_PREFIX,
      ST_EMIT
   } state_type;

endpackage

>>> sv/tghc_ram.sv
// ----------------------------------------------------------------------------
// tghc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tghc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tghc_cell.sv
// ----------------------------------------------------------------------------
// tghc_cell
// One cell of the insertion-sort chain: holds one time with its hit index.
// ----------------------------------------------------------------------------
module tghc_cell #(
   parameter int TIME_BITS = tghc_pkg::TIME_BITS_DEF,
   parameter int DATA_W    = tghc_pkg::TIME_BITS_DEF + 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tghc_pkg::cell_ctl_type     ctl,
   input  logic [DATA_W-1:0]          new_data,
   input  logic                       left_vld,
   input  logic                       left_gt,
   input  logic [DATA_W-1:0]          left_data,
   input  logic                       right_vld,
   input  logic [DATA_W-1:0]          right_data,
   output logic                       vld,
   output logic                       gt,
   output logic [DATA_W-1:0]          data
);

   logic              vld_ff, vld_in;
   logic [DATA_W-1:0] data_ff, data_in;

   // own time is later than the incoming one
   assign gt = vld_ff && (data_ff[TIME_BITS-1:0] > new_data[TIME_BITS-1:0]);

   // shift towards the head, or make room and insert
   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (ctl.shl) begin
         vld_in  = right_vld;
         data_in = right_data;
      end else if (ctl.ins) begin
         if (left_gt) begin
            vld_in  = 1'b1;
            data_in = left_data;
         end else if (gt || (!vld_ff && left_vld)) begin
            vld_in  = 1'b1;
            data_in = new_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign vld  = vld_ff;
   assign data = data_ff;

endmodule

>>> sv/time_gap_hit_clusterer_top.sv
// ----------------------------------------------------------------------------
// time_gap_hit_clusterer_top
// Sorts the hit times of one event, splits them into groups at wide gaps,
// keeps groups with enough hits and reports one word per hit in input order.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_word          taken when start and not busy
//  result    rsp_strobe, rsp_word           one word per cycle, no stall
//  config    psel/penable/pwrite/paddr/...  APB write, pready tied high
//
// Loading takes one hit per cycle; each hit is inserted into a chain of sort
// cells in that cycle. After the last hit the chain shifts out its hits, then
// follow a flush step, a pass over the groups and the emit pipeline.
// Busy stays high from the last hit until the emit pipeline has drained.
// Reset is synchronous and empties the chain; the result side cannot stall.
// ----------------------------------------------------------------------------
module time_gap_hit_clusterer_top #(
   parameter int MAX_HITS  = tghc_pkg::MAX_HITS_DEF,
   parameter int TIME_BITS = tghc_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  tghc_pkg::req_type                   req_word,
   output logic                                rsp_strobe,
   output tghc_pkg::rsp_type                   rsp_word,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tghc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tghc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tghc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int IDX_W  = $clog2(MAX_HITS);
   localparam int CNT_W  = $clog2(MAX_HITS + 1);
   localparam int DATA_W = IDX_W + TIME_BITS;
   localparam int CMP_W  = (TIME_BITS > tghc_pkg::GAP_W) ? TIME_BITS : tghc_pkg::GAP_W;
   localparam int MH_W   = (CNT_W > tghc_pkg::MINH_W) ? CNT_W : tghc_pkg::MINH_W;

   tghc_pkg::state_type state_ff, state_in;

   logic [tghc_pkg::GAP_W-1:0]  max_gap_ff;
   logic [tghc_pkg::MINH_W-1:0] min_hits_ff;

   logic [CNT_W-1:0]     hit_count_ff, hit_count_in;
   logic                 overflow_ff, overflow_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [TIME_BITS-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0]     gid_ff, gid_in;
   logic [CNT_W-1:0]     gcnt_ff, gcnt_in;
   logic [CNT_W-1:0]     total_ff, total_in;

   logic             pre_vld_ff, pre_vld_in;
   logic [IDX_W-1:0] pre_g_ff;
   logic             e1_vld_ff, e1_vld_in;
   logic [IDX_W-1:0] e1_idx_ff;
   logic             e1_last_ff, e1_last_in;
   logic             e2_vld_ff;
   logic [IDX_W-1:0] e2_idx_ff;
   logic [IDX_W-1:0] e2_g_ff;
   logic             e2_last_ff;
   logic             rsp_strobe_ff;
   tghc_pkg::rsp_type rsp_word_ff, rsp_word_in;

   logic                   accept;
   logic                   full;
   logic [TIME_BITS-1:0]   t_in;
   logic [DATA_W-1:0]      new_data;
   tghc_pkg::cell_ctl_type ctl;

   logic              c_vld  [MAX_HITS];
   logic              c_gt   [MAX_HITS];
   logic [DATA_W-1:0] c_data [MAX_HITS];

   logic [TIME_BITS-1:0] cur_time;
   logic [IDX_W-1:0]     cur_idx;
   logic [TIME_BITS-1:0] diff;
   logic                 brk;
   logic [IDX_W-1:0]     gid_now;
   logic [CNT_W-1:0]     ngroups;
   logic                 kflag;

   logic             grp_we;
   logic [IDX_W-1:0] grp_rd;
   logic             cnt_we;
   logic [CNT_W-1:0] cnt_rd;
   logic             keep_we;
   logic [IDX_W:0]   keep_rd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff  <= tghc_pkg::MAX_GAP_RST;
         min_hits_ff <= tghc_pkg::MIN_HITS_RST;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            tghc_pkg::REG_MAX_GAP:  max_gap_ff  <= pwdata[tghc_pkg::GAP_W-1:0];
            tghc_pkg::REG_MIN_HITS: min_hits_ff <= pwdata[tghc_pkg::MINH_W-1:0];
            default: ;
         endcase
      end
   end

   assign prdata = (paddr[2] == tghc_pkg::REG_MIN_HITS) ?
                   tghc_pkg::CSR_DATA_W'(min_hits_ff) : tghc_pkg::CSR_DATA_W'(max_gap_ff);
   assign pready = 1'b1;

   // load side
   assign busy     = (state_ff != tghc_pkg::ST_LOAD);
   assign accept   = start && !busy;
   assign full     = (hit_count_ff == CNT_W'(MAX_HITS));
   assign t_in     = TIME_BITS'(req_word.hit_time);
   assign new_data = {hit_count_ff[IDX_W-1:0], t_in};
   assign ctl.ins  = accept && !full;
   assign ctl.shl  = (state_ff == tghc_pkg::ST_SCAN);

   // sort chain, head at cell 0
   genvar j;
   generate
      for (j = 0; j < MAX_HITS; j++) begin : g_cell
         logic              l_vld, l_gt, r_vld;
         logic [DATA_W-1:0] l_data, r_data;
         if (j == 0) begin : g_head
            assign l_vld  = 1'b1;
            assign l_gt   = 1'b0;
            assign l_data = new_data;
         end else begin : g_body
            assign l_vld  = c_vld[j-1];
            assign l_gt   = c_gt[j-1];
            assign l_data = c_data[j-1];
         end
         if (j == MAX_HITS - 1) begin : g_tail
            assign r_vld  = 1'b0;
            assign r_data = new_data;
         end else begin : g_mid
            assign r_vld  = c_vld[j+1];
            assign r_data = c_data[j+1];
         end
         tghc_cell #(
            .TIME_BITS (TIME_BITS),
            .DATA_W    (DATA_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_data   (new_data),
            .left_vld   (l_vld),
            .left_gt    (l_gt),
            .left_data  (l_data),
            .right_vld  (r_vld),
            .right_data (r_data),
            .vld        (c_vld[j]),
            .gt         (c_gt[j]),
            .data       (c_data[j])
         );
      end
   endgenerate

   // gap detection on the head of the chain
   assign cur_time = c_data[0][TIME_BITS-1:0];
   assign cur_idx  = c_data[0][DATA_W-1:TIME_BITS];
   assign diff     = cur_time - prev_ff;
   assign brk      = (k_ff != '0) && (CMP_W'(diff) > CMP_W'(max_gap_ff));
   assign gid_now  = (k_ff == '0) ? '0 : (brk ? gid_ff + 1'b1 : gid_ff);
   assign ngroups  = CNT_W'(gid_ff) + 1'b1;
   assign kflag    = MH_W'(cnt_rd) >= MH_W'(min_hits_ff);

   // group of every hit, by hit index
   assign grp_we = (state_ff == tghc_pkg::ST_SCAN);
   tghc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_HITS)) u_grp_ram (
      .clock   (clock),
      .wr_en   (grp_we),
      .wr_addr (cur_idx),
      .wr_data (gid_now),
      .rd_addr (k_ff[IDX_W-1:0]),
      .rd_data (grp_rd)
   );

   // hit count of every group
   assign cnt_we = ((state_ff == tghc_pkg::ST_SCAN) && brk) ||
                   (state_ff == tghc_pkg::ST_FLUSH);
   tghc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_HITS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (gid_ff),
      .wr_data (gcnt_ff),
      .rd_addr (k_ff[IDX_W-1:0]),
      .rd_data (cnt_rd)
   );

   // kept flag and dense subevent number of every group
   assign keep_we = pre_vld_ff;
   tghc_ram #(.WIDTH(IDX_W + 1), .DEPTH(MAX_HITS)) u_keep_ram (
      .clock   (clock),
      .wr_en   (keep_we),
      .wr_addr (pre_g_ff),
      .wr_data ({kflag, total_ff[IDX_W-1:0]}),
      .rd_addr (grp_rd),
      .rd_data (keep_rd)
   );

   // sequencer: next state and control
   always_comb begin
      state_in     = state_ff;
      hit_count_in = hit_count_ff;
      overflow_in  = overflow_ff;
      k_in         = k_ff;
      prev_in      = prev_ff;
      gid_in       = gid_ff;
      gcnt_in      = gcnt_ff;
      total_in     = total_ff;
      pre_vld_in   = 1'b0;
      e1_vld_in    = 1'b0;
      e1_last_in   = 1'b0;
      unique case (state_ff)
         tghc_pkg::ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  hit_count_in = hit_count_ff + 1'b1;
               end
               if (req_word.last_hit) begin
                  k_in     = '0;
                  state_in = tghc_pkg::ST_SCAN;
               end
            end
         end
         tghc_pkg::ST_SCAN: begin
            prev_in = cur_time;
            gid_in  = gid_now;
            gcnt_in = ((k_ff == '0) || brk) ? CNT_W'(1) : gcnt_ff + 1'b1;
            k_in    = k_ff + 1'b1;
            if (k_ff == hit_count_ff - 1'b1) begin
               state_in = tghc_pkg::ST_FLUSH;
            end
         end
         tghc_pkg::ST_FLUSH: begin
            k_in     = '0;
            total_in = '0;
            state_in = tghc_pkg::ST_PREFIX;
         end
         tghc_pkg::ST_PREFIX: begin
            if (pre_vld_ff && kflag) begin
               total_in = total_ff + 1'b1;
            end
            if (k_ff != ngroups) begin
               pre_vld_in = 1'b1;
               k_in       = k_ff + 1'b1;
            end else if (!pre_vld_ff) begin
               k_in     = '0;
               state_in = tghc_pkg::ST_EMIT;
            end
         end
         tghc_pkg::ST_EMIT: begin
            if (k_ff != hit_count_ff) begin
               e1_vld_in  = 1'b1;
               e1_last_in = (k_ff == hit_count_ff - 1'b1);
               k_in       = k_ff + 1'b1;
            end else if (!e1_vld_ff && !e2_vld_ff && !rsp_strobe_ff) begin
               hit_count_in = '0;
               overflow_in  = 1'b0;
               state_in     = tghc_pkg::ST_LOAD;
            end
         end
         default: state_in = tghc_pkg::ST_LOAD;
      endcase
   end

   // result word from the last emit stage
   always_comb begin
      rsp_word_in.hit_index       = tghc_pkg::IDX_OUT_W'(e2_idx_ff);
      rsp_word_in.group_number    = tghc_pkg::IDX_OUT_W'(e2_g_ff);
      rsp_word_in.kept            = keep_rd[IDX_W];
      rsp_word_in.subevent_number = keep_rd[IDX_W] ?
                                    tghc_pkg::IDX_OUT_W'(keep_rd[IDX_W-1:0]) : '0;
      rsp_word_in.subevent_total  = tghc_pkg::TOT_W'(total_ff);
      rsp_word_in.overflowed      = overflow_ff;
      rsp_word_in.last_result     = e2_last_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tghc_pkg::ST_LOAD;
         hit_count_ff  <= '0;
         overflow_ff   <= 1'b0;
         k_ff          <= '0;
         pre_vld_ff    <= 1'b0;
         e1_vld_ff     <= 1'b0;
         e2_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hit_count_ff  <= hit_count_in;
         overflow_ff   <= overflow_in;
         k_ff          <= k_in;
         pre_vld_ff    <= pre_vld_in;
         e1_vld_ff     <= e1_vld_in;
         e2_vld_ff     <= e1_vld_ff;
         rsp_strobe_ff <= e2_vld_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      gid_ff      <= gid_in;
      gcnt_ff     <= gcnt_in;
      total_ff    <= total_in;
      pre_g_ff    <= k_ff[IDX_W-1:0];
      e1_idx_ff   <= k_ff[IDX_W-1:0];
      e1_last_ff  <= e1_last_in;
      e2_idx_ff   <= e1_idx_ff;
      e2_g_ff     <= grp_rd;
      e2_last_ff  <= e1_last_ff;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // checks
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result word outside an event");

   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.last_result) |=> !rsp_strobe)
      else $error("result word after the last one");

   a_scan_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tghc_pkg::ST_SCAN) |-> c_vld[0])
      else $error("sort chain empty during scan");

endmodule
